[rtl/core/lhr_pkg.sv]
// Shared widths, constants and control types for the largest histogram rectangle unit.
package lhr_pkg;

  localparam int HEIGHT_W = 32;
  localparam int AREA_W   = 48;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [AREA_W-1:0]   area_t;

  // Control from the sequencer to the area scoring pipeline.
  typedef struct packed {
    logic valid;  // score one popped stack entry
    logic clear;  // reset the running best area for the next histogram
  } lhr_score_ctl_t;

endpackage

[rtl/core/lhr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module lhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lhr_score.sv]
// Area scoring pipeline: span subtract result in, multiply, saturate and keep the maximum.
module lhr_score
  import lhr_pkg::*;
#(
  parameter int SPAN_W = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  lhr_score_ctl_t ctl,
  input  height_t        height,
  input  logic [SPAN_W-1:0] span,
  output area_t          best,
  output logic           busy
);

  localparam int PROD_W = HEIGHT_W + SPAN_W;
  localparam int CMP_W  = PROD_W > AREA_W ? PROD_W : AREA_W;

  logic              v1;
  logic              v2;
  height_t           h1;
  logic [SPAN_W-1:0] span1;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  prod_ext;
  area_t             area_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    h1    <= height;
    span1 <= span;
    prod  <= PROD_W'(h1) * PROD_W'(span1);
  end

  always_comb begin
    prod_ext = CMP_W'(prod);
    area_sat = (prod_ext > CMP_W'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= '0;
    end else if (v2 && (area_sat > best)) begin
      best <= area_sat;
    end
  end

  assign busy = v1 | v2;

endmodule

[rtl/core/largest_histogram_rectangle_unit.sv]
// Each bar is compared with the stack top; a bar that pops nothing is pushed. Each stack
// entry it pops is scored and the next entry is read from RAM, unless that pop empties the stack.
// After the last bar the flush scores each remaining entry, reading the next one from RAM until
// the stack is empty, then waits for the multiply pipeline to drain and for the master side to be
// free, and the result is registered on the master side. Each bar is pushed once and popped at most once.
// rst is synchronous: it clears the stack depth, bar count and best area; RAM is not cleared.
module largest_histogram_rectangle_unit
  import lhr_pkg::*;
#(
  parameter int MAX_BARS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [HEIGHT_W-1:0] s_tdata,  // [31:0] height
  input  logic              s_tlast,  // is_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [AREA_W-1:0] m_tdata   // [47:0] max_area
);

  localparam int IDX_W = $clog2(MAX_BARS + 1);
  localparam int AW    = MAX_BARS > 1 ? $clog2(MAX_BARS) : 1;
  localparam int ENT_W = HEIGHT_W + AW;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_CMP        = 3'd1;
  localparam logic [2:0] ST_LOAD       = 3'd2;
  localparam logic [2:0] ST_FLUSH      = 3'd3;
  localparam logic [2:0] ST_FLUSH_LOAD = 3'd4;
  localparam logic [2:0] ST_DRAIN      = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] depth;
  logic [IDX_W-1:0] depth_next;
  logic [IDX_W-1:0] bar_count;
  logic [IDX_W-1:0] bar_count_next;
  logic [IDX_W-1:0] depth_m2;
  height_t          top_h;
  logic [AW-1:0]    top_s;
  height_t          cur_h;
  logic             cur_last;
  logic [AW-1:0]    start;

  logic             pop;
  logic             ram_we;
  logic [ENT_W-1:0] ram_rdata;
  logic [IDX_W-1:0] span;
  lhr_score_ctl_t   score_ctl;
  area_t            best;
  logic             score_busy;
  logic             out_free;

  assign s_tready = (state == ST_IDLE);
  assign depth_m2 = depth - IDX_W'(2);
  assign span     = bar_count - IDX_W'(top_s);
  assign pop      = (depth != '0) && (top_h >= cur_h);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next      = state;
    depth_next      = depth;
    bar_count_next  = bar_count;
    ram_we          = 1'b0;
    score_ctl.valid = 1'b0;
    score_ctl.clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (bar_count < IDX_W'(MAX_BARS)) begin
            state_next = ST_CMP;
          end else if (s_tlast) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_CMP: begin
        if (pop) begin
          score_ctl.valid = 1'b1;
          depth_next      = depth - IDX_W'(1);
          // The new top lives in RAM; fetch it unless the stack becomes empty.
          state_next      = (depth > IDX_W'(1)) ? ST_LOAD : ST_CMP;
        end else begin
          ram_we         = depth < IDX_W'(MAX_BARS);
          depth_next     = ram_we ? depth + IDX_W'(1) : depth;
          bar_count_next = bar_count + IDX_W'(1);
          state_next     = cur_last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_LOAD: begin
        state_next = ST_CMP;
      end
      ST_FLUSH: begin
        if (depth != '0) begin
          score_ctl.valid = 1'b1;
          depth_next      = depth - IDX_W'(1);
          state_next      = (depth > IDX_W'(1)) ? ST_FLUSH_LOAD : ST_DRAIN;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_FLUSH_LOAD: begin
        state_next = ST_FLUSH;
      end
      ST_DRAIN: begin
        if (!score_busy && out_free) begin
          score_ctl.clear = 1'b1;
          depth_next      = '0;
          bar_count_next  = '0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      bar_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      bar_count <= bar_count_next;
      if (state == ST_DRAIN && !score_busy && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cur_h    <= s_tdata;
      cur_last <= s_tlast;
      start    <= bar_count[AW-1:0];
    end
    if (state == ST_CMP && pop) begin
      start <= top_s;
    end
    if (ram_we) begin
      top_h <= cur_h;
      top_s <= start;
    end
    if (state == ST_LOAD || state == ST_FLUSH_LOAD) begin
      top_h <= ram_rdata[HEIGHT_W-1:0];
      top_s <= ram_rdata[ENT_W-1:HEIGHT_W];
    end
    if (state == ST_DRAIN && !score_busy && out_free) begin
      m_tdata <= best;
    end
  end

  lhr_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_BARS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(depth[AW-1:0]),
    .wdata({start, cur_h}),
    .raddr(depth_m2[AW-1:0]),
    .rdata(ram_rdata)
  );

  lhr_score #(
    .SPAN_W(IDX_W)
  ) u_score (
    .clk   (clk),
    .rst   (rst),
    .ctl   (score_ctl),
    .height(top_h),
    .span  (span),
    .best  (best),
    .busy  (score_busy)
  );

  a_depth_le_count: assert property (@(posedge clk) disable iff (rst)
    depth <= bar_count)
    else $error("stack deeper than the number of bars");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    bar_count <= IDX_W'(MAX_BARS))
    else $error("bar count past its cap");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_FLUSH_LOAD) |-> depth != '0)
    else $error("stack top fetched from an empty stack");

  a_result_drained: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!score_busy))
    else $error("result presented while areas were still being scored");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    score_ctl.clear |-> !score_busy && !score_ctl.valid)
    else $error("best area cleared with a score in flight");

endmodule

[tb/largest_histogram_rectangle_unit_tb.sv]
// Self-checking testbench for the largest histogram rectangle unit, with a stack-based area predictor.
`timescale 1ns / 1ps

module largest_histogram_rectangle_unit_tb;
  import lhr_pkg::*;

  localparam int unsigned MAX_BARS    = 65536;
  localparam int unsigned RANDOM_BARS = 1050;
  localparam int unsigned HOLD_CYCLES = 400;
  // The limit leaves room for the deepest flush of a long histogram.
  localparam int unsigned STALL_LIMIT = 300000;

  // Predicts the area of each histogram and keeps the areas still owed by the block.
  class lhr_scoreboard;
    int unsigned bar_limit;
    height_t     run_height[$];
    int unsigned run_start[$];
    int unsigned bars;
    logic [63:0] best;
    area_t       area_q[$];
    int unsigned errors;

    function new(int unsigned max_bars);
      bar_limit = max_bars;
      bars = 0;
      best = '0;
      errors = 0;
    endfunction

    function void score(height_t h, int unsigned first, int unsigned stop);
      logic [63:0] area;
      area = 64'(h) * 64'(stop - first);
      if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
      if (area > best) best = area;
    endfunction

    function void note_bar(height_t h, bit last);
      int unsigned first;
      if (bars < bar_limit) begin
        first = bars;
        // Every stacked bar at least as high as the new one ends here.
        while (run_height.size() > 0 && run_height[$] >= h) begin
          score(run_height[$], run_start[$], bars);
          first = run_start[$];
          void'(run_height.pop_back());
          void'(run_start.pop_back());
        end
        run_height.push_back(h);
        run_start.push_back(first);
        bars++;
      end
      if (last) begin
        while (run_height.size() > 0) begin
          score(run_height[$], run_start[$], bars);
          void'(run_height.pop_back());
          void'(run_start.pop_back());
        end
        area_q.push_back(best[AREA_W-1:0]);
        bars = 0;
        best = '0;
      end
    endfunction

    function void check_area(area_t got);
      area_t want;
      if (area_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected area result: actual %0d", got);
        return;
      end
      want = area_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("area mismatch: expected %0d actual %0d", want, got);
      end
    endfunction

    function int unsigned pending();
      return area_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  height_t     s_tdata = '0;  // [31:0] height
  logic        s_tlast = 1'b0;  // is_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  area_t       m_tdata;  // [47:0] max_area

  lhr_scoreboard area_sb = new(MAX_BARS);

  bit          src_idle_on = 1'b1;
  logic        snk_idle_on = 1'b1;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned bars_sent = 0;

  always #1 clk = ~clk;

  largest_histogram_rectangle_unit #(
    .MAX_BARS(MAX_BARS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Result side: checks accepted areas and drives m_tready, including one long hold-off.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) area_sb.check_area(m_tdata);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(snk_idle_on && $urandom_range(99) < 38);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("largest_histogram_rectangle_unit_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_bar(input height_t h, input bit last);
    while (src_idle_on && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    area_sb.note_bar(h, last);
    bars_sent++;
  endtask

  task automatic send_histogram(input height_t heights[$]);
    foreach (heights[i]) send_bar(heights[i], i == heights.size() - 1);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (area_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic height_t pick_height(int unsigned kind, int unsigned pos);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(7);
      2: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return pos * 3 + $urandom_range(4);
    endcase
  endfunction

  initial begin
    height_t     bars_q[$];
    int unsigned len;
    int unsigned kind;
    int unsigned pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Short directed histograms: extremes, all zeros, ramps, plateaus, a classic mix.
    send_histogram('{32'd0});
    send_histogram('{32'hFFFF_FFFF});
    send_histogram('{32'd0, 32'd0, 32'd0});
    send_histogram('{32'd1, 32'd2, 32'd3, 32'd4, 32'd5});
    send_histogram('{32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
    send_histogram('{32'd7, 32'd7, 32'd7});
    send_histogram('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_histogram('{32'd2, 32'd1, 32'd5, 32'd6, 32'd2, 32'd3});
    drain_results();

    // The result side stalls for a long stretch while short histograms keep coming.
    hold_req <= 1'b1;
    bars_sent = 0;
    while (bars_sent < RANDOM_BARS) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 32);
      else len = $urandom_range(33, 200);
      kind = $urandom_range(3);
      bars_q.delete();
      for (int unsigned i = 0; i < len; i++) bars_q.push_back(pick_height(kind, i));
      if (bars_sent >= 500 && bars_sent < 750) begin
        src_idle_on = 1'b0;
        snk_idle_on <= 1'b0;
      end else begin
        src_idle_on = 1'b1;
        snk_idle_on <= 1'b1;
      end
      send_histogram(bars_q);
      if (bars_sent >= 300 && bars_sent < 300 + len) drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (area_sb.errors == 0 && area_sb.pending() == 0) begin
      $display("largest_histogram_rectangle_unit_tb: clean");
    end else begin
      $display("largest_histogram_rectangle_unit_tb: errors");
    end
    $finish;
  end

endmodule
